// ===== rtl/bbcq_pkg.sv =====
package bbcq_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int CAP_W       = 24;
    localparam int SAMPLES_W   = 14;
    localparam int COST_W      = 16;
    localparam int OUT_CNT_W   = 9;

    localparam logic [CAP_W-1:0] CAP_RESET    = 24'd1048576;
    localparam logic [CAP_W-1:0] TARGET_RESET = 24'd786432;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_CLEAR = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_ACCEPTED    = 2'd0,
        ST_DROP_BUDGET = 2'd1,
        ST_DROP_FULL   = 2'd2,
        ST_CLEARED     = 2'd3
    } t_status;

    typedef struct packed {
        logic              clr;
        logic [COST_W-1:0] cost;
    } t_cmd;

    typedef struct packed {
        t_status              status;
        logic [OUT_CNT_W-1:0] evicted;
        logic [CAP_W-1:0]     used;
        logic [OUT_CNT_W-1:0] stored;
    } t_result;

endpackage

// ===== rtl/bbcq_front.sv =====
module bbcq_front
    import bbcq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_func,
    input  logic [SAMPLES_W-1:0] i_chunk_samples,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_pop
);

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_wr, w_rd;
    t_cmd               w_cmd;

    assign o_full      = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_comb begin
        w_cmd.clr  = (t_func'(i_func) == FUNC_CLEAR);
        w_cmd.cost = {i_chunk_samples, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ===== rtl/bbcq_out_q.sv =====
module bbcq_out_q
    import bbcq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_data
);

    t_result            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_wr, w_rd;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/bbcq_back.sv =====
module bbcq_back
    import bbcq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_res_full,
    output logic             o_res_wr,
    output t_result          o_res
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVICT  = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    logic [COST_W-1:0] mem [MAX_ENTRIES];
    logic [COST_W-1:0] r_rd;

    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap, r_target;
    logic [IDX_W-1:0]  r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count, r_evict, n_evict;
    logic [CAP_W-1:0]  r_bytes, n_bytes;
    logic [COST_W-1:0] r_cost, n_cost;
    logic              w_mem_we;
    logic [CAP_W+1:0]  w_cap3;
    logic [CAP_W:0]    w_sum_cmd, w_sum_cur;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        next_slot = (idx == IDX_W'(MAX_ENTRIES - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign w_cap3    = {2'b00, i_cfg_wdata} + {1'b0, i_cfg_wdata, 1'b0};
    assign w_sum_cmd = {1'b0, r_bytes} + (CAP_W + 1)'(i_cmd.cost);
    assign w_sum_cur = {1'b0, r_bytes} + (CAP_W + 1)'(r_cost);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_evict   = r_evict;
        n_bytes   = r_bytes;
        n_cost    = r_cost;
        w_mem_we  = 1'b0;
        o_cmd_pop = 1'b0;
        o_res_wr  = 1'b0;
        o_res     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.clr) begin
                        n_head       = '0;
                        n_tail       = '0;
                        n_count      = '0;
                        n_bytes      = '0;
                        o_res_wr     = 1'b1;
                        o_res.status = ST_CLEARED;
                    end else begin
                        n_cost  = i_cmd.cost;
                        n_evict = '0;
                        n_state = (w_sum_cmd > {1'b0, r_cap}) ? S_EVICT : S_DECIDE;
                    end
                end
            end
            S_EVICT: begin
                if (r_count != '0 && r_bytes > r_target) begin
                    n_bytes = (r_bytes >= CAP_W'(r_rd)) ? r_bytes - CAP_W'(r_rd) : '0;
                    n_head  = next_slot(r_head);
                    n_count = r_count - 1'b1;
                    n_evict = r_evict + 1'b1;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_sum_cur > {1'b0, r_cap}) begin
                    o_res.status = ST_DROP_BUDGET;
                end else if (r_count == CNT_W'(MAX_ENTRIES)) begin
                    o_res.status = ST_DROP_FULL;
                end else begin
                    w_mem_we     = 1'b1;
                    n_tail       = next_slot(r_tail);
                    n_count      = r_count + 1'b1;
                    n_bytes      = w_sum_cur[CAP_W-1:0];
                    o_res.status = ST_ACCEPTED;
                end
                o_res_wr      = 1'b1;
                o_res.evicted = OUT_CNT_W'(r_evict);
                o_res.used    = n_bytes;
                o_res.stored  = OUT_CNT_W'(n_count);
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= CAP_RESET;
            r_target <= TARGET_RESET;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_evict  <= '0;
            r_bytes  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_evict <= n_evict;
            r_bytes <= n_bytes;
            if (i_cfg_we) begin
                r_cap    <= i_cfg_wdata;
                r_target <= w_cap3[CAP_W+1:2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cost <= n_cost;
        r_rd   <= mem[n_head];
        if (w_mem_we) begin
            mem[r_tail] <= r_cost;
        end
    end

endmodule

// ===== rtl/byte_budget_chunk_queue.sv =====
// Byte-budget chunk queue. Each item either clears the queue or adds a chunk whose
// cost is four bytes per sample; when an add would exceed the capacity, the oldest
// chunks are evicted until the held bytes are at most three quarters of capacity,
// and the chunk is then accepted or dropped, giving exactly one result per item.
// An add that fits the budget goes straight to the decision; one that goes over budget
// first passes through the eviction loop, which reads one stored chunk cost per cycle
// from the chunk-size memory. A two-entry queue in front and a two-entry result queue
// let items arrive and results drain while the engine works. Write capacity only while
// no item is in flight.
module byte_budget_chunk_queue
    import bbcq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_func,
    input  logic [SAMPLES_W-1:0] i_chunk_samples,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    output logic [OUT_CNT_W-1:0] o_evicted_chunks,
    output logic [CAP_W-1:0]     o_used_bytes,
    output logic [OUT_CNT_W-1:0] o_stored_chunks
);

    logic    w_cmd_valid, w_cmd_pop, w_res_full, w_res_wr;
    t_cmd    w_cmd;
    t_result w_res, w_out;

    bbcq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_func          (i_func),
        .i_chunk_samples (i_chunk_samples),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    bbcq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_wr    (w_res_wr),
        .o_res       (w_res)
    );

    bbcq_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (w_out)
    );

    assign o_status         = w_out.status;
    assign o_evicted_chunks = w_out.evicted;
    assign o_used_bytes     = w_out.used;
    assign o_stored_chunks  = w_out.stored;

endmodule

// ===== bench/byte_budget_chunk_queue_tb.sv =====
module byte_budget_chunk_queue_tb
    import bbcq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 300;

    typedef struct {
        t_func                fn;
        logic [SAMPLES_W-1:0] samples;
    } t_chunk_req;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata   = '0;
    logic                 push        = 1'b0;
    logic                 full;
    t_func                drv_func    = FUNC_ADD;
    logic [SAMPLES_W-1:0] drv_samples = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [1:0]           res_status;
    logic [OUT_CNT_W-1:0] res_evicted;
    logic [CAP_W-1:0]     res_used;
    logic [OUT_CNT_W-1:0] res_stored;

    t_chunk_req  chunk_reqs[$];
    t_result     verdicts[$];

    logic [COST_W-1:0] chunk_costs [MAX_ENTRIES];
    int unsigned       oldest_slot  = 0;
    int unsigned       free_slot    = 0;
    int unsigned       held_chunks  = 0;
    int unsigned       held_bytes   = 0;
    int unsigned       budget       = CAP_RESET;

    int unsigned drv_gap      = 0;
    int unsigned drv_gap_max  = 8;
    int unsigned mon_gap      = 0;
    int unsigned mon_gap_max  = 8;
    int unsigned stall_cycles = 0;

    int unsigned n_sent         = 0;
    int unsigned n_results      = 0;
    int unsigned n_errors       = 0;
    int unsigned n_settings     = 0;
    int unsigned n_full_drops   = 0;
    int unsigned n_budget_drops = 0;
    int unsigned max_evicted    = 0;

    byte_budget_chunk_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .push            (push),
        .full            (full),
        .i_func          (drv_func),
        .i_chunk_samples (drv_samples),
        .empty           (empty),
        .pop             (pop),
        .o_status        (res_status),
        .o_evicted_chunks(res_evicted),
        .o_used_bytes    (res_used),
        .o_stored_chunks (res_stored)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result admit_chunk(input t_func fn, input logic [SAMPLES_W-1:0] samples);
        t_result     r;
        int unsigned cost;
        int unsigned target;
        int unsigned evicted;
        int unsigned c;
        cost    = 32'(samples) << 2;
        evicted = 0;
        if (fn == FUNC_CLEAR) begin
            oldest_slot = 0;
            free_slot   = 0;
            held_chunks = 0;
            held_bytes  = 0;
            r.status    = ST_CLEARED;
        end else begin
            if (held_bytes + cost > budget) begin
                target = (budget * 3) / 4;
                while (held_chunks > 0 && held_bytes > target) begin
                    c           = chunk_costs[oldest_slot];
                    held_bytes  = (held_bytes >= c) ? held_bytes - c : 0;
                    oldest_slot = (oldest_slot + 1) % MAX_ENTRIES;
                    held_chunks = held_chunks - 1;
                    evicted     = evicted + 1;
                end
            end
            if (held_bytes + cost > budget) begin
                r.status       = ST_DROP_BUDGET;
                n_budget_drops = n_budget_drops + 1;
            end else if (held_chunks >= MAX_ENTRIES) begin
                r.status     = ST_DROP_FULL;
                n_full_drops = n_full_drops + 1;
            end else begin
                chunk_costs[free_slot] = COST_W'(cost);
                free_slot   = (free_slot + 1) % MAX_ENTRIES;
                held_chunks = held_chunks + 1;
                held_bytes  = (held_bytes + cost) & 32'hFF_FFFF;
                r.status    = ST_ACCEPTED;
            end
        end
        if (evicted > max_evicted) begin
            max_evicted = evicted;
        end
        r.evicted = OUT_CNT_W'(evicted);
        r.used    = CAP_W'(held_bytes);
        r.stored  = OUT_CNT_W'(held_chunks);
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            n_errors = n_errors + 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : chunk_driver
        t_chunk_req nxt;
        t_result    pred;
        if (!i_rst_n) begin
            push    <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (push && !full) begin
                pred     = admit_chunk(drv_func, drv_samples);
                verdicts = {verdicts, pred};
                n_sent   = n_sent + 1;
            end
            if (!push || !full) begin
                if (drv_gap != 0) begin
                    push    <= 1'b0;
                    drv_gap <= drv_gap - 1;
                end else if (chunk_reqs.size() != 0) begin
                    nxt = chunk_reqs.pop_front();
                    push        <= 1'b1;
                    drv_func    <= nxt.fn;
                    drv_samples <= nxt.samples;
                    drv_gap     <= $urandom_range(0, drv_gap_max);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result     want;
        int unsigned g;
        if (!i_rst_n) begin
            pop     <= 1'b0;
            mon_gap <= 0;
        end else if (pop && !empty) begin
            if (verdicts.size() == 0) begin
                n_errors = n_errors + 1;
                $display("%0t: result with none expected, expected nothing, actual status %0d",
                         $time, res_status);
            end else begin
                want = verdicts.pop_front();
                check_field("status", want.status, res_status);
                check_field("evicted_chunks", want.evicted, res_evicted);
                check_field("used_bytes", want.used, res_used);
                check_field("stored_chunks", want.stored, res_stored);
            end
            n_results = n_results + 1;
            g = (n_results == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, mon_gap_max);
            if (g != 0) begin
                pop     <= 1'b0;
                mon_gap <= g;
            end
        end else if (mon_gap != 0) begin
            mon_gap <= mon_gap - 1;
            if (mon_gap == 1) begin
                pop <= 1'b1;
            end
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_req(input t_func fn, input logic [SAMPLES_W-1:0] samples);
        t_chunk_req r;
        r.fn       = fn;
        r.samples  = samples;
        chunk_reqs = {chunk_reqs, r};
    endtask

    task automatic load_random(input int n, input int unsigned clr_pct,
                               input int unsigned small_max);
        t_func                fn;
        logic [SAMPLES_W-1:0] samples;
        for (int k = 0; k < n; k++) begin
            fn = ($urandom_range(0, 99) < clr_pct) ? FUNC_CLEAR : FUNC_ADD;
            if ($urandom_range(0, 3) == 0) begin
                samples = $urandom_range(0, 16383);
            end else begin
                samples = $urandom_range(0, small_max);
            end
            add_req(fn, samples);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (chunk_reqs.size() != 0 || push || verdicts.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        budget     = value;
        n_settings = n_settings + 1;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset capacity: fill with the largest chunks until one overflows and evicts.
        add_req(FUNC_ADD, 0);
        repeat (17) add_req(FUNC_ADD, 16383);
        add_req(FUNC_ADD, 14'h2AAA);
        add_req(FUNC_ADD, 14'h1555);
        add_req(FUNC_CLEAR, 16383);
        add_req(FUNC_ADD, 1);
        add_req(FUNC_CLEAR, 0);

        // Fill every slot, hit the full store, then drop the capacity to zero.
        drv_gap_max = 0;
        mon_gap_max = 0;
        set_capacity(24'd1024);
        add_req(FUNC_CLEAR, 0);
        repeat (MAX_ENTRIES) add_req(FUNC_ADD, 1);
        add_req(FUNC_ADD, 0);
        set_capacity(24'd0);
        add_req(FUNC_ADD, 1);
        add_req(FUNC_ADD, 0);
        add_req(FUNC_ADD, 16383);

        drv_gap_max = 8;
        mon_gap_max = 8;
        set_capacity(24'hFF_FFFF);
        load_random(300, 2, 16383);

        set_capacity(CAP_W'($urandom_range(1000, 300000)));
        load_random(300, 3, 255);

        drv_gap_max = 0;
        set_capacity(CAP_W'($urandom_range(0, 24'hFF_FFFF)));
        load_random(200, 2, 4095);

        drv_gap_max = 3;
        mon_gap_max = 0;
        set_capacity(CAP_RESET);
        load_random(200, 5, 16383);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d items and checked %0d results under %0d capacity settings.",
                 n_sent, n_results, n_settings);
        $display("Saw %0d over-budget drops, %0d store-full drops, up to %0d evictions at once.",
                 n_budget_drops, n_full_drops, max_evicted);
        if (n_errors == 0 && verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
